/* design/hrhl_pkg.sv */
// Shared types, constants and character tables for the HTTP request
// host locator. No dependencies; the other design files but hrhl_in_if import it.
`default_nettype none

package hrhl_pkg;

  localparam int unsigned PACKET_BYTES_DEF = 2048;
  localparam int unsigned OFF_W            = 11;
  localparam int unsigned METH_N           = 9;

  typedef logic [OFF_W-1:0] off_t;

  localparam logic [2:0] ST_NOT_HTTP      = 3'd0;
  localparam logic [2:0] ST_REQ_INCOMPL   = 3'd1;
  localparam logic [2:0] ST_VALUE_TRUNC   = 3'd2;
  localparam logic [2:0] ST_NO_HOST       = 3'd3;
  localparam logic [2:0] ST_HOST_FOUND    = 3'd4;

  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [2:0] NAME_MISS = 3'd7;
  localparam logic [2:0] NAME_HIT  = 3'd4;

  // Method prefixes, left-justified, padded with spaces past their size.
  localparam logic [63:0] METH_TEXT [METH_N] = '{
    "GET     ", "POST    ", "PUT     ", "DELETE  ", "HEAD    ",
    "OPTIONS ", "CONNECT ", "PATCH   ", "TRACE   "
  };
  localparam logic [3:0] METH_SIZE [METH_N] = '{
    4'd4, 4'd5, 4'd4, 4'd7, 4'd5, 4'd8, 4'd8, 4'd6, 4'd6
  };

  localparam logic [31:0] HOST_TEXT = "host";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } hrhl_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] verb_len;
    off_t       target_off;
    off_t       target_len;
    off_t       host_name_off;
    off_t       host_val_off;
    off_t       host_val_len;
  } hrhl_out_t;

endpackage

`default_nettype wire

/* design/hrhl_in_if.sv */
// Byte input channel: valid/ready handshake carrying one packet byte
// and its last-byte flag. No dependencies.
`default_nettype none

interface hrhl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* design/hrhl_out_if.sv */
// Result channel: valid/ready handshake carrying one locator result.
// Depends on hrhl_pkg.
`default_nettype none

interface hrhl_out_if import hrhl_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] verb_len;
  off_t       target_off;
  off_t       target_len;
  off_t       host_name_off;
  off_t       host_val_off;
  off_t       host_val_len;

  modport source(output valid, status, verb_len, target_off, target_len,
                 host_name_off, host_val_off, host_val_len, input ready);
  modport sink(input valid, status, verb_len, target_off, target_len,
               host_name_off, host_val_off, host_val_len, output ready);
endinterface

`default_nettype wire

/* design/http_request_host_locator.sv */
// HTTP request host locator: top level with input and result registers.
// Depends on hrhl_pkg, hrhl_in_if, hrhl_out_if and hrhl_parser.
//
// One packet byte is taken per transfer, every cycle while results drain.
// A byte is registered in the input register, then stepped through the
// parse state once the result register can take a result, and any result
// lands in the output register at that same edge. The single parse step,
// whose state feeds back on itself each byte, sets the rate of one byte
// per cycle while the result register is not stalled. At most one result
// per packet: at the LF of the Host line, or else at the last byte. Bytes
// beyond PACKET_BYTES do not change the parse; offsets and lengths are
// reported modulo 2048.
`default_nettype none

module http_request_host_locator import hrhl_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  hrhl_in_if.sink    bytes_in,
  hrhl_out_if.source result
);

  logic      s1_valid;
  hrhl_in_t  s1_item;
  logic      s1_adv;
  logic      step;
  logic      res_valid;
  hrhl_out_t res;
  logic      out_valid;
  hrhl_out_t out_q;

  assign s1_adv         = !out_valid || result.ready;
  assign step           = s1_valid && s1_adv;
  assign bytes_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes_in.ready) begin
      s1_valid <= bytes_in.valid;
    end
    if (bytes_in.ready && bytes_in.valid) begin
      s1_item.data_byte <= bytes_in.data_byte;
      s1_item.last_byte <= bytes_in.last_byte;
    end
  end

  hrhl_parser #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (s1_item),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !result.ready) || (step && res_valid);
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_q.status;
  assign result.verb_len      = out_q.verb_len;
  assign result.target_off    = out_q.target_off;
  assign result.target_len    = out_q.target_len;
  assign result.host_name_off = out_q.host_name_off;
  assign result.host_val_off  = out_q.host_val_off;
  assign result.host_val_len  = out_q.host_val_len;

endmodule

`default_nettype wire

/* design/hrhl_parser.sv */
// Per-byte parse state and its one-step update; forms the result for the
// byte being stepped. Depends on hrhl_pkg.
`default_nettype none

module hrhl_parser import hrhl_pkg::*; #(
  parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire hrhl_in_t  item,
  output logic           res_valid,
  output hrhl_out_t      res
);

  localparam int unsigned POS_W = $clog2(PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LIM = POS_W'(PACKET_BYTES);

  typedef enum logic [3:0] {
    PH_METHOD, PH_NOT_HTTP, PH_TARGET, PH_REQLINE, PH_LINE, PH_LINE_CR,
    PH_NAME, PH_SKIP, PH_OWS, PH_VALUE, PH_HDR_END, PH_DONE
  } phase_t;

  function automatic logic token_byte(input logic [7:0] c);
    logic ok;
    ok = (c > CH_SP) && (c < CH_DEL);
    case (c) inside
      // ( ) , / : ; < = > ? @ [ \ ] { } "
      8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D, 8'h22: ok = 1'b0;
      default: ;
    endcase
    return ok;
  endfunction

  phase_t           phase, phase_n;
  logic [POS_W-1:0] pos;
  logic [8:0]       cand, cand_n;
  logic [2:0]       mlen, mlen_n;
  off_t             tstart, tstart_n;
  off_t             tlen, tlen_n;
  off_t             lstart, lstart_n;
  logic [2:0]       prog, prog_n;
  off_t             vstart, vstart_n;
  off_t             vend, vend_n;
  logic             pcr, pcr_n;
  logic             given;

  logic       active;
  off_t       pos_off;
  logic [7:0] b;
  logic       is_ows;

  // name character step
  logic [2:0] nm_prog_in;
  logic [7:0] nm_low;
  phase_t     nm_phase;
  logic       nm_pcr;
  logic [2:0] nm_prog;

  // value character step
  logic       vs_pcr_in;
  off_t       vs_end_in;
  logic       vs_pcr;
  off_t       vs_end;

  assign b       = item.data_byte;
  assign active  = step && !given && (pos < POS_LIM);
  assign pos_off = OFF_W'(pos);
  assign is_ows  = (b == CH_SP) || (b == CH_HT);

  always_comb begin
    nm_prog_in = (phase == PH_LINE) ? 3'd0 : prog;
    nm_low     = ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
    nm_phase   = PH_NAME;
    nm_pcr     = pcr;
    nm_prog    = nm_prog_in;
    if (b == CH_COLON) begin
      nm_phase = PH_OWS;
    end else if (b == CH_CR) begin
      nm_phase = PH_SKIP;
      nm_pcr   = 1'b1;
    end else if (!token_byte(b)) begin
      nm_phase = PH_SKIP;
      nm_pcr   = 1'b0;
    end else if ((nm_prog_in < NAME_HIT) &&
                 (nm_low == HOST_TEXT[8*(3-nm_prog_in[1:0]) +: 8])) begin
      nm_prog = nm_prog_in + 3'd1;
    end else begin
      nm_prog = NAME_MISS;
    end
  end

  always_comb begin
    vs_pcr_in = (phase == PH_OWS) ? 1'b0 : pcr;
    vs_end_in = (phase == PH_OWS) ? pos_off : vend;
    vs_end    = vs_pcr_in ? pos_off : vs_end_in;
    vs_pcr    = (b == CH_CR);
    if ((b != CH_CR) && !is_ows) begin
      vs_end = pos_off + OFF_W'(1);
    end
  end

  always_comb begin
    phase_n  = phase;
    cand_n   = cand;
    mlen_n   = mlen;
    tstart_n = tstart;
    tlen_n   = tlen;
    lstart_n = lstart;
    prog_n   = prog;
    vstart_n = vstart;
    vend_n   = vend;
    pcr_n    = pcr;
    if (active) begin
      unique case (phase)
        PH_METHOD: begin
          for (int k = 0; k < METH_N; k++) begin
            if (cand[k]) begin
              if ((pos >= POS_W'(METH_SIZE[k])) ||
                  (b != METH_TEXT[k][8*(7-pos[2:0]) +: 8])) begin
                cand_n[k] = 1'b0;
              end else if (pos + POS_W'(1) == POS_W'(METH_SIZE[k])) begin
                mlen_n   = pos[2:0];
                tstart_n = pos_off + OFF_W'(1);
                tlen_n   = '0;
                phase_n  = PH_TARGET;
              end
            end
          end
          if ((phase_n == PH_METHOD) && (cand_n == '0)) begin
            phase_n = PH_NOT_HTTP;
          end
        end
        PH_TARGET: begin
          if (b == CH_SP) begin
            phase_n = PH_REQLINE;
            pcr_n   = 1'b0;
          end else begin
            tlen_n = tlen + OFF_W'(1);
          end
        end
        PH_REQLINE, PH_SKIP: begin
          if (pcr && (b == CH_LF)) begin
            phase_n = PH_LINE;
            pcr_n   = 1'b0;
          end else begin
            pcr_n = (b == CH_CR);
          end
        end
        PH_LINE: begin
          lstart_n = pos_off;
          if (b == CH_CR) begin
            phase_n = PH_LINE_CR;
            prog_n  = 3'd0;
          end else begin
            phase_n = nm_phase;
            pcr_n   = nm_pcr;
            prog_n  = nm_prog;
          end
        end
        PH_LINE_CR: begin
          if (b == CH_LF) begin
            phase_n = PH_HDR_END;
          end else begin
            phase_n = PH_SKIP;
            pcr_n   = (b == CH_CR);
          end
        end
        PH_NAME: begin
          phase_n = nm_phase;
          pcr_n   = nm_pcr;
          prog_n  = nm_prog;
        end
        PH_OWS: begin
          if (!is_ows) begin
            vstart_n = pos_off;
            vend_n   = vs_end;
            pcr_n    = vs_pcr;
            phase_n  = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (pcr && (b == CH_LF)) begin
            pcr_n   = 1'b0;
            phase_n = (prog == NAME_HIT) ? PH_DONE : PH_LINE;
          end else begin
            vend_n = vs_end;
            pcr_n  = vs_pcr;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (active && (phase_n == PH_DONE)) begin
      res_valid  = 1'b1;
      res.status = ST_HOST_FOUND;
    end else if (step && item.last_byte && !given) begin
      res_valid = 1'b1;
      unique case (phase_n) inside
        PH_METHOD, PH_NOT_HTTP: res.status = ST_NOT_HTTP;
        PH_TARGET, PH_REQLINE:  res.status = ST_REQ_INCOMPL;
        PH_OWS, PH_VALUE:       res.status = ST_VALUE_TRUNC;
        default:                res.status = ST_NO_HOST;
      endcase
    end
    if (res.status != ST_NOT_HTTP) begin
      res.verb_len = mlen_n;
    end
    if (res.status >= ST_VALUE_TRUNC) begin
      res.target_off = tstart_n;
      res.target_len = tlen_n;
    end
    if (res.status == ST_HOST_FOUND) begin
      res.host_name_off = lstart_n;
      res.host_val_off  = vstart_n;
      res.host_val_len  = vend_n - vstart_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase  <= PH_METHOD;
      pos    <= '0;
      cand   <= '1;
      mlen   <= '0;
      tstart <= '0;
      tlen   <= '0;
      lstart <= '0;
      prog   <= '0;
      vstart <= '0;
      vend   <= '0;
      pcr    <= 1'b0;
      given  <= 1'b0;
    end else if (active) begin
      phase  <= phase_n;
      pos    <= pos + POS_W'(1);
      cand   <= cand_n;
      mlen   <= mlen_n;
      tstart <= tstart_n;
      tlen   <= tlen_n;
      lstart <= lstart_n;
      prog   <= prog_n;
      vstart <= vstart_n;
      vend   <= vend_n;
      pcr    <= pcr_n;
      given  <= res_valid;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for the HTTP request host locator: directed and random packets
// checked against an in-bench parse predictor. Depends on hrhl_pkg,
// hrhl_in_if, hrhl_out_if and http_request_host_locator.
`timescale 1ns / 100ps

module tb_top;
  import hrhl_pkg::*;

  localparam int unsigned PACKET_BYTES = PACKET_BYTES_DEF;

  typedef enum logic [3:0] {
    PH_METHOD, PH_NOT_HTTP, PH_TARGET, PH_REQLINE, PH_LINE, PH_LINE_CR,
    PH_NAME, PH_SKIP, PH_OWS, PH_VALUE, PH_HDR_END, PH_DONE
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hrhl_in_if  bytes_ch ();
  hrhl_out_if result_ch ();

  http_request_host_locator #(.PACKET_BYTES(PACKET_BYTES)) u_top (
    .clk(clk),
    .rst(rst),
    .bytes_in(bytes_ch),
    .result(result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string meth_word [9] = '{
    "GET ", "POST ", "PUT ", "DELETE ", "HEAD ",
    "OPTIONS ", "CONNECT ", "PATCH ", "TRACE "
  };
  string host_word = "host";

  // parse predictor state
  parse_phase_t ph;
  int unsigned  pos_now, meth_len, tgt_start, tgt_len, hdr_start, value_begin, val_end;
  logic [8:0]   meth_alive;
  logic [2:0]   host_hits;
  bit           cr_seen, reported;

  hrhl_out_t  host_reports_due [$];
  hrhl_in_t   byte_queue [$];
  logic [7:0] pkt_bytes [$];

  int total_bytes = 0;
  int bytes_taken = 0;
  int bytes_offered = 0;
  int mismatches = 0;
  int cycle_no = 0;
  int ready_cycle = 0;
  int stall_left = 0;

  function automatic void parser_clear();
    ph = PH_METHOD;
    pos_now = 0;
    meth_alive = '1;
    meth_len = 0;
    tgt_start = 0;
    tgt_len = 0;
    hdr_start = 0;
    host_hits = '0;
    value_begin = 0;
    val_end = 0;
    cr_seen = 1'b0;
    reported = 1'b0;
  endfunction

  function automatic bit is_token(logic [7:0] c);
    if (c <= CH_SP || c >= CH_DEL) return 1'b0;
    case (c)
      "(", ")", ",", "/", ":", ";", "<", "=", ">", "?",
      "@", "[", "\\", "]", "{", "}", "\"": return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic void take_name_char(logic [7:0] b);
    logic [7:0] low;
    if (b == CH_COLON) begin
      ph = PH_OWS;
    end else if (b == CH_CR) begin
      ph = PH_SKIP;
      cr_seen = 1'b1;
    end else if (!is_token(b)) begin
      ph = PH_SKIP;
      cr_seen = 1'b0;
    end else begin
      low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      if (host_hits < NAME_HIT && low == host_word[host_hits]) host_hits = host_hits + 3'd1;
      else host_hits = NAME_MISS;
      ph = PH_NAME;
    end
  endfunction

  function automatic void take_value_char(logic [7:0] b, int unsigned p);
    if (cr_seen) val_end = p;
    if (b == CH_CR) begin
      cr_seen = 1'b1;
    end else begin
      cr_seen = 1'b0;
      if (b != CH_SP && b != CH_HT) val_end = p + 1;
    end
  endfunction

  function automatic hrhl_out_t make_report(logic [2:0] st);
    hrhl_out_t r;
    r = '0;
    r.status = st;
    if (st >= ST_REQ_INCOMPL) r.verb_len = meth_len[2:0];
    if (st >= ST_VALUE_TRUNC) begin
      r.target_off = tgt_start[10:0];
      r.target_len = tgt_len[10:0];
    end
    if (st == ST_HOST_FOUND) begin
      r.host_name_off = hdr_start[10:0];
      r.host_val_off  = value_begin[10:0];
      r.host_val_len  = off_t'(val_end - value_begin);
    end
    return r;
  endfunction

  function automatic void locate_step(logic [7:0] b, logic last);
    int unsigned p;
    logic [2:0]  st;
    p = pos_now;
    if (!reported && p < PACKET_BYTES) begin
      case (ph)
        PH_METHOD: begin
          for (int k = 0; k < 9; k++) begin
            if (meth_alive[k]) begin
              if (p >= meth_word[k].len() || b != meth_word[k][p]) begin
                meth_alive[k] = 1'b0;
              end else if (p + 1 == meth_word[k].len()) begin
                meth_len = p;
                tgt_start = p + 1;
                tgt_len = 0;
                ph = PH_TARGET;
              end
            end
          end
          if (ph == PH_METHOD && meth_alive == '0) ph = PH_NOT_HTTP;
        end
        PH_TARGET: begin
          if (b == CH_SP) begin
            ph = PH_REQLINE;
            cr_seen = 1'b0;
          end else begin
            tgt_len++;
          end
        end
        PH_REQLINE, PH_SKIP: begin
          if (cr_seen && b == CH_LF) begin
            ph = PH_LINE;
            cr_seen = 1'b0;
          end else begin
            cr_seen = (b == CH_CR);
          end
        end
        PH_LINE: begin
          hdr_start = p;
          host_hits = '0;
          if (b == CH_CR) ph = PH_LINE_CR;
          else take_name_char(b);
        end
        PH_LINE_CR: begin
          if (b == CH_LF) begin
            ph = PH_HDR_END;
          end else begin
            ph = PH_SKIP;
            cr_seen = (b == CH_CR);
          end
        end
        PH_NAME: take_name_char(b);
        PH_OWS: begin
          if (b != CH_SP && b != CH_HT) begin
            value_begin = p;
            val_end = p;
            cr_seen = 1'b0;
            ph = PH_VALUE;
            take_value_char(b, p);
          end
        end
        PH_VALUE: begin
          if (cr_seen && b == CH_LF) begin
            cr_seen = 1'b0;
            ph = (host_hits == NAME_HIT) ? PH_DONE : PH_LINE;
          end else begin
            take_value_char(b, p);
          end
        end
        default: ;
      endcase
      pos_now++;
      if (ph == PH_DONE) begin
        host_reports_due.push_back(make_report(ST_HOST_FOUND));
        reported = 1'b1;
      end
    end
    if (last) begin
      if (!reported) begin
        case (ph)
          PH_METHOD, PH_NOT_HTTP: st = ST_NOT_HTTP;
          PH_TARGET, PH_REQLINE:  st = ST_REQ_INCOMPL;
          PH_OWS, PH_VALUE:       st = ST_VALUE_TRUNC;
          default:                st = ST_NO_HOST;
        endcase
        host_reports_due.push_back(make_report(st));
      end
      parser_clear();
    end
  endfunction

  // stimulus helpers
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
  endtask

  task automatic send_packet();
    hrhl_in_t item;
    if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom_range(255)));
    foreach (pkt_bytes[i]) begin
      item.data_byte = pkt_bytes[i];
      item.last_byte = (i == pkt_bytes.size() - 1);
      byte_queue.push_back(item);
    end
    pkt_bytes.delete();
  endtask

  function automatic logic [7:0] rand_visible();
    return 8'($urandom_range(8'h7E, 8'h21));
  endfunction

  function automatic logic [7:0] rand_value_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return CH_SP;
    if (r < 15) return CH_HT;
    if (r < 20) return CH_CR;
    if (r < 30) return 8'($urandom_range(255));
    return rand_visible();
  endfunction

  task automatic put_line_end();
    case ($urandom_range(19))
      0:       put_text("\r");
      1:       put_text("\n");
      2:       put_text("\r\r\n");
      default: put_text("\r\n");
    endcase
  endtask

  task automatic build_random_packet();
    int unsigned kind, n;
    logic [7:0]  c;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(30, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    put_text(meth_word[$urandom_range(8)]);
    if (kind < 14) pkt_bytes[$urandom_range(pkt_bytes.size() - 1)] = 8'($urandom_range(255));
    repeat ($urandom_range(6)) begin
      c = ($urandom_range(99) < 85) ? rand_visible() : 8'($urandom_range(255));
      pkt_bytes.push_back(c == CH_SP ? 8'h2F : c);
    end
    put_text(" ");
    if ($urandom_range(1)) put_text("HTTP/1.1");
    else repeat ($urandom_range(3)) pkt_bytes.push_back(rand_visible());
    put_line_end();
    repeat ($urandom_range(3)) begin
      case ($urandom_range(9))
        0, 1: put_text("Host");
        2:    put_text("host");
        3:    put_text("HOST");
        4:    put_text("hOsT");
        5:    put_text("Hos");
        6:    put_text("Hosts");
        7:    put_text("Accept");
        8:    repeat ($urandom_range(4)) pkt_bytes.push_back(rand_visible());
        default: repeat ($urandom_range(3, 1)) pkt_bytes.push_back(8'($urandom_range(255)));
      endcase
      if ($urandom_range(99) < 92) pkt_bytes.push_back(CH_COLON);
      repeat ($urandom_range(2)) pkt_bytes.push_back($urandom_range(1) ? CH_SP : CH_HT);
      repeat ($urandom_range(6)) pkt_bytes.push_back(rand_value_char());
      repeat ($urandom_range(2)) pkt_bytes.push_back($urandom_range(1) ? CH_SP : CH_HT);
      put_line_end();
    end
    if ($urandom_range(99) < 70) begin
      put_text("\r\n");
      repeat ($urandom_range(4)) pkt_bytes.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(pkt_bytes.size(), 1);
      pkt_bytes = pkt_bytes[0:n-1];
    end
  endtask

  function automatic bit take_gap();
    bit steady;
    steady = (cycle_no >= 600 && cycle_no < 900);
    return !steady && ($urandom_range(99) < 18);
  endfunction

  // byte driver: hold the offered byte until its transfer, then advance
  always @(negedge clk) begin
    hrhl_in_t item;
    if (rst) begin
      bytes_ch.valid <= 1'b0;
    end else if (!(bytes_ch.valid && bytes_taken != bytes_offered)) begin
      if (byte_queue.size() != 0 && !take_gap()) begin
        item = byte_queue.pop_front();
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= item.data_byte;
        bytes_ch.last_byte <= item.last_byte;
        bytes_offered++;
      end else begin
        bytes_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus one long hold-off early in the run
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      ready_cycle++;
      if (ready_cycle == 100) stall_left = 400;
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !take_gap();
      end
    end
  end

  // monitor: predict on each byte transfer, check each result transfer
  always @(posedge clk) begin
    hrhl_out_t got, want;
    if (!rst) begin
      cycle_no <= cycle_no + 1;
      if (bytes_ch.valid && bytes_ch.ready) begin
        locate_step(bytes_ch.data_byte, bytes_ch.last_byte);
        bytes_taken <= bytes_taken + 1;
      end
      if (result_ch.valid && result_ch.ready) begin
        got.status        = result_ch.status;
        got.verb_len      = result_ch.verb_len;
        got.target_off    = result_ch.target_off;
        got.target_len    = result_ch.target_len;
        got.host_name_off = result_ch.host_name_off;
        got.host_val_off  = result_ch.host_val_off;
        got.host_val_len  = result_ch.host_val_len;
        if (host_reports_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result, status %0d", $realtime, got.status);
          mismatches++;
        end else begin
          want = host_reports_due.pop_front();
          if (got.status !== want.status || got.verb_len !== want.verb_len ||
              got.target_off !== want.target_off || got.target_len !== want.target_len ||
              got.host_name_off !== want.host_name_off ||
              got.host_val_off !== want.host_val_off ||
              got.host_val_len !== want.host_val_len) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected st %0d meth %0d tgt %0d/%0d host %0d val %0d/%0d",
                       want.status, want.verb_len, want.target_off, want.target_len,
                       want.host_name_off, want.host_val_off, want.host_val_len);
              $display("  actual   st %0d meth %0d tgt %0d/%0d host %0d val %0d/%0d",
                       got.status, got.verb_len, got.target_off, got.target_len,
                       got.host_name_off, got.host_val_off, got.host_val_len);
            end
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    bytes_ch.valid     = 1'b0;
    bytes_ch.data_byte = '0;
    bytes_ch.last_byte = 1'b0;
    result_ch.ready    = 1'b0;
    parser_clear();

    // directed packets
    put_text("GET / HTTP/1.1\r\nHost: example.com\r\n\r\n"); send_packet();
    put_text("POST /a HTTP/1.1\r\nAccept: */*\r\nhost:\t x.org \t\r\n\r\n"); send_packet();
    put_text("PUT /p H\r\nHOST:y\r\n"); send_packet();
    put_text("DELETE /d H\r\nhOsT:   \r\n"); send_packet();
    put_text("HEAD  H\r\nHost: h\r\ntrailing junk"); send_packet();
    put_text("OPTIONS * HTTP/1.1\r\nX-A: 1\r\n\r\nHost: z\r\n"); send_packet();
    put_text("CONNECT h:443 HTTP/1.1\r\nHo\rst: a\r\nHost: b\rc \r\r\n"); send_packet();
    put_text("PATCH /q H\r\nHo st: a\r\nHostx\r\n:Host\r\nHos: a\r\nHosts: a\r\n");
    put_text("Host: ok\r\n"); send_packet();
    put_text("TRACE / H\r\nHost: trunc"); send_packet();
    put_text("GET /abc"); send_packet();
    put_text("GXT / H\r\n"); send_packet();
    put_text("G"); send_packet();
    pkt_bytes.push_back(8'h00); pkt_bytes.push_back(8'hFF); send_packet();
    put_text("GET / H\r\nAcc"); send_packet();
    put_text("GET / H\r\nA(b: x\r\nHost"); send_packet();
    put_text("GET / H\r\n\r\rHost: a\r\n"); send_packet();
    put_text("GET / H\r\nHost:"); send_packet();
    put_text("GET / H\r\nName"); pkt_bytes.push_back(CH_DEL); put_text(": x\r\n");
    pkt_bytes.push_back(8'h80); put_text("Host: y\r\nHost: ");
    pkt_bytes.push_back(8'hFF); put_text("\r\n"); send_packet();
    put_text("GET / H\n\r\nHost: a\r\n"); send_packet();

    while (byte_queue.size() < 700) begin
      build_random_packet();
      send_packet();
    end
    total_bytes = byte_queue.size();

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (bytes_taken < total_bytes || host_reports_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
design/hrhl_pkg.sv
design/hrhl_in_if.sv
design/hrhl_out_if.sv
design/hrhl_parser.sv
design/http_request_host_locator.sv
tb/tb_top.sv
